@@ hdl/rxs_pkg.sv @@
// Shared types and constants for the receive ring buffer with RTS flow control.
// Used by the sniffer, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package rxs_pkg;

   localparam int unsigned DEFAULT_DEPTH = 256;

   localparam logic [7:0] CODE_DLE = 8'h10;
   localparam logic [7:0] CODE_EOT = 8'h04;
   localparam logic [7:0] CODE_ENQ = 8'h05;
   localparam logic [7:0] FN_STATUS = 8'h04;
   localparam logic [7:0] FN_WAKE = 8'h02;

   localparam logic [7:0] STOP_LEVEL_RESET = 8'd32;
   localparam logic [7:0] RESUME_LEVEL_RESET = 8'd64;

   localparam logic [7:0] CSR_STOP_LEVEL = 8'd0;
   localparam logic [7:0] CSR_RESUME_LEVEL = 8'd1;

   typedef enum logic [1:0] {
      OP_LINE  = 2'd0,
      OP_POP   = 2'd1,
      OP_LOCAL = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DLE  = 2'd1,
      PH_EOT  = 2'd2,
      PH_ENQ  = 2'd3
   } phase_type;

   typedef struct packed {
      logic status;
      logic wake;
   } sniff_type;

endpackage

@@ hdl/rxs_sniffer.sv @@
// Real-time command detector for DLE EOT and DLE ENQ sequences.
// Depends on rxs_pkg for the phase type, the command codes and the pulse struct.
`timescale 1ns / 1ps

module rxs_sniffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   input  logic              printer_ready,
   output rxs_pkg::sniff_type pulses
);
   import rxs_pkg::*;

   phase_type phase_ff;
   phase_type phase_in;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == CODE_DLE) phase_in = PH_DLE;
         end
         PH_DLE: begin
            if (rx_byte == CODE_EOT) phase_in = PH_EOT;
            else if (rx_byte == CODE_ENQ) phase_in = PH_ENQ;
            else if (rx_byte != CODE_DLE) phase_in = PH_IDLE;
         end
         PH_EOT: phase_in = PH_IDLE;
         PH_ENQ: phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      pulses = '0;
      case (phase_ff)
         PH_EOT: pulses.status = step && (rx_byte == FN_STATUS);
         PH_ENQ: pulses.wake = step && (rx_byte == FN_WAKE) && !printer_ready;
         default: pulses = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

endmodule

@@ hdl/rxs_ram.sv @@
// Byte store of the ring: one write port and one read port with registered data.
// Contents are undefined until written; no package dependencies.
`timescale 1ns / 1ps

module rxs_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          write_en,
   input  logic [AW-1:0] write_addr,
   input  logic [7:0]    write_data,
   input  logic          read_en,
   input  logic [AW-1:0] read_addr,
   output logic [7:0]    read_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ hdl/rx_fifo_rts_realtime_sniffer.sv @@
// Top level: receive ring buffer with RTS hysteresis and real-time command sniffer.
// Depends on rxs_pkg, rxs_sniffer and rxs_ram.
//
//   Channel   Prefix  Direction  Contents
//   request   req_    in         operation, rx_byte, line_error, printer_ready
//   response  rsp_    out        pop_valid, pop_byte, rts_stop, pulses, overflow, fill_count
//   control   csr_    in         register index and write data
//
// One transfer per cycle is sustained in both directions while rsp_ready is high; each
// item passes through the input register, then the result register and memory read.
// Reset clears the indices, the fill count, the detector and RTS, and returns both
// levels to their reset values; the byte memory is not cleared. While rsp_ready is
// low the result register holds, the input register fills, and then req_ready drops.
`timescale 1ns / 1ps

module rx_fifo_rts_realtime_sniffer #(
   parameter int unsigned BUFFER_DEPTH = rxs_pkg::DEFAULT_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_rx_byte,
   input  logic       req_line_error,
   input  logic       req_printer_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pop_valid,
   output logic [7:0] rsp_pop_byte,
   output logic       rsp_rts_stop,
   output logic       rsp_status_request,
   output logic       rsp_wake_request,
   output logic       rsp_overflow,
   output logic [7:0] rsp_fill_count,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_data
);
   import rxs_pkg::*;

   localparam int unsigned IDXW = $clog2(BUFFER_DEPTH);
   localparam int unsigned CMPW = (IDXW > 8) ? IDXW : 8;
   localparam logic [IDXW-1:0] LAST_INDEX = IDXW'(BUFFER_DEPTH - 1);

   logic            in_valid_ff, in_valid_in;
   op_type          in_op_ff;
   logic [7:0]      in_byte_ff;
   logic            in_err_ff;
   logic            in_ready_ff;

   logic [IDXW-1:0] write_index_ff, write_index_in;
   logic [IDXW-1:0] read_index_ff, read_index_in;
   logic [IDXW-1:0] count_ff, count_in;
   logic            rts_ff, rts_in;
   logic [7:0]      stop_level_ff, resume_level_ff;

   logic            out_valid_ff, out_valid_in;
   logic            out_pop_valid_ff;
   logic            out_status_ff, out_wake_ff, out_overflow_ff;
   logic [7:0]      out_fill_ff;

   logic            exec;
   logic            full, push_op, stored, pop_ok, line_ok;
   logic [IDXW-1:0] free_next;
   logic [CMPW-1:0] free_wide, count_wide;
   logic [7:0]      fill_sat;
   logic [7:0]      ram_rdata;
   sniff_type       pulses;

   assign exec = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec;
   assign csr_ready = 1'b1;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (exec ? 1'b0 : in_valid_ff);
   assign out_valid_in = exec ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff <= op_type'(req_operation);
         in_byte_ff <= req_rx_byte;
         in_err_ff <= req_line_error;
         in_ready_ff <= req_printer_ready;
      end
   end

   assign line_ok = (in_op_ff == OP_LINE) && !in_err_ff;
   assign full = (count_ff == LAST_INDEX);
   assign push_op = line_ok || (in_op_ff == OP_LOCAL);
   assign stored = push_op && !full;
   assign pop_ok = (in_op_ff == OP_POP) && (count_ff != '0);

   always_comb begin
      write_index_in = write_index_ff;
      read_index_in = read_index_ff;
      count_in = count_ff;
      case (in_op_ff)
         OP_CLEAR: begin
            write_index_in = '0;
            read_index_in = '0;
            count_in = '0;
         end
         OP_POP: begin
            if (pop_ok) begin
               read_index_in = (read_index_ff == LAST_INDEX) ? '0 : read_index_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            if (stored) begin
               write_index_in = (write_index_ff == LAST_INDEX) ? '0 : write_index_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
      endcase
   end

   assign free_next = LAST_INDEX - count_in;
   assign free_wide = CMPW'(free_next);
   assign count_wide = CMPW'(count_in);
   assign fill_sat = (count_wide > CMPW'(255)) ? 8'hFF : count_wide[7:0];

   always_comb begin
      rts_in = rts_ff;
      if (line_ok && (free_wide < CMPW'(stop_level_ff))) rts_in = 1'b1;
      if (pop_ok && (free_wide > CMPW'(resume_level_ff))) rts_in = 1'b0;
   end

   rxs_sniffer u_sniffer (
      .clock         (clock),
      .reset         (reset),
      .step          (exec && line_ok),
      .rx_byte       (in_byte_ff),
      .printer_ready (in_ready_ff),
      .pulses        (pulses)
   );

   rxs_ram #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (IDXW)
   ) u_ram (
      .clock      (clock),
      .write_en   (exec && stored),
      .write_addr (write_index_ff),
      .write_data (in_byte_ff),
      .read_en    (exec && pop_ok),
      .read_addr  (read_index_ff),
      .read_data  (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         write_index_ff <= '0;
         read_index_ff <= '0;
         count_ff <= '0;
         rts_ff <= 1'b0;
         stop_level_ff <= STOP_LEVEL_RESET;
         resume_level_ff <= RESUME_LEVEL_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (exec) begin
            write_index_ff <= write_index_in;
            read_index_ff <= read_index_in;
            count_ff <= count_in;
            rts_ff <= rts_in;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_STOP_LEVEL) stop_level_ff <= csr_data;
            if (csr_index == CSR_RESUME_LEVEL) resume_level_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_pop_valid_ff <= pop_ok;
         out_status_ff <= pulses.status;
         out_wake_ff <= pulses.wake;
         out_overflow_ff <= push_op && full;
         out_fill_ff <= fill_sat;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pop_valid = out_pop_valid_ff;
   assign rsp_pop_byte = out_pop_valid_ff ? ram_rdata : 8'h00;
   assign rsp_rts_stop = rts_ff;
   assign rsp_status_request = out_status_ff;
   assign rsp_wake_request = out_wake_ff;
   assign rsp_overflow = out_overflow_ff;
   assign rsp_fill_count = out_fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_INDEX)
      else $error("fill count beyond ring capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (CMPW'(rsp_fill_count) ==
         ((CMPW'(LAST_INDEX) > CMPW'(255)) ? CMPW'(255) : CMPW'(LAST_INDEX))))
      else $error("overflow reported while the ring was not full");

   a_pop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pop_valid && (rsp_overflow || rsp_status_request
         || rsp_wake_request)))
      else $error("pop result carries a push-side flag");

   a_index_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (write_index_ff == read_index_ff))
      else $error("empty ring with differing indices");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for rx_fifo_rts_realtime_sniffer: drives request items and register
// writes, predicts every response with its own ring, detector and RTS model, and checks them.
// Depends on rxs_pkg and the rx_fifo_rts_realtime_sniffer top level.
`timescale 1ns / 1ps

module tb_top;
   import rxs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       pop_valid;
      logic [7:0] pop_byte;
      logic       rts_stop;
      logic       status_request;
      logic       wake_request;
      logic       overflow;
      logic [7:0] fill_count;
   } rx_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_operation;
   logic [7:0] req_rx_byte;
   logic       req_line_error;
   logic       req_printer_ready;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_pop_valid;
   logic [7:0] rsp_pop_byte;
   logic       rsp_rts_stop;
   logic       rsp_status_request;
   logic       rsp_wake_request;
   logic       rsp_overflow;
   logic [7:0] rsp_fill_count;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_index;
   logic [7:0] csr_data;

   logic [7:0] ring_bytes [256];
   logic [7:0] model_wr;
   logic [7:0] model_rd;
   phase_type  model_phase;
   logic       model_rts;
   logic [7:0] model_stop;
   logic [7:0] model_resume;

   rx_result_type due_results[$];
   int         mismatch_count = 0;
   int         items_sent = 0;
   int         cycle_count = 0;
   int         hold_off_cycles = 0;
   logic       gaps_on = 1'b1;

   rx_fifo_rts_realtime_sniffer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_rx_byte        (req_rx_byte),
      .req_line_error     (req_line_error),
      .req_printer_ready  (req_printer_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pop_valid      (rsp_pop_valid),
      .rsp_pop_byte       (rsp_pop_byte),
      .rsp_rts_stop       (rsp_rts_stop),
      .rsp_status_request (rsp_status_request),
      .rsp_wake_request   (rsp_wake_request),
      .rsp_overflow       (rsp_overflow),
      .rsp_fill_count     (rsp_fill_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic any_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [7:0] free_slots();
      return 8'd255 - 8'(model_wr - model_rd);
   endfunction

   function automatic logic ring_push(input logic [7:0] value);
      logic [7:0] nx;
      nx = model_wr + 8'd1;
      if (nx == model_rd) return 1'b0;
      ring_bytes[model_wr] = value;
      model_wr = nx;
      return 1'b1;
   endfunction

   function automatic rx_result_type ring_step(input op_type op, input logic [7:0] value,
                                                input logic err, input logic ready);
      rx_result_type r;
      r = '0;
      case (op)
         OP_LINE: begin
            if (!err) begin
               case (model_phase)
                  PH_IDLE: if (value == CODE_DLE) model_phase = PH_DLE;
                  PH_DLE: begin
                     if (value == CODE_EOT) model_phase = PH_EOT;
                     else if (value == CODE_ENQ) model_phase = PH_ENQ;
                     else if (value != CODE_DLE) model_phase = PH_IDLE;
                  end
                  PH_EOT: begin
                     r.status_request = (value == FN_STATUS);
                     model_phase = PH_IDLE;
                  end
                  default: begin
                     r.wake_request = (value == FN_WAKE) && !ready;
                     model_phase = PH_IDLE;
                  end
               endcase
               r.overflow = !ring_push(value);
               if (free_slots() < model_stop) model_rts = 1'b1;
            end
         end
         OP_POP: begin
            if (model_wr != model_rd) begin
               r.pop_valid = 1'b1;
               r.pop_byte = ring_bytes[model_rd];
               model_rd = model_rd + 8'd1;
               if (free_slots() > model_resume) model_rts = 1'b0;
            end
         end
         OP_LOCAL: r.overflow = !ring_push(value);
         default: begin
            model_wr = '0;
            model_rd = '0;
         end
      endcase
      r.rts_stop = model_rts;
      r.fill_count = model_wr - model_rd;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns: MISMATCH %s", $time, msg);
   endtask

   task automatic send_item(input op_type op, input logic [7:0] value, input logic err,
                            input logic ready);
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_rx_byte <= value;
      req_line_error <= err;
      req_printer_ready <= ready;
      do @(posedge clock); while (!req_ready);
      due_results.push_back(ring_step(op, value, err, ready));
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_STOP_LEVEL) model_stop = value;
      else if (idx == CSR_RESUME_LEVEL) model_resume = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_levels(input logic [7:0] stop, input logic [7:0] resume);
      drain();
      write_csr(CSR_STOP_LEVEL, stop);
      write_csr(CSR_RESUME_LEVEL, resume);
   endtask

   task automatic send_realtime_command();
      logic rdy;
      int   n;
      rdy = any_bit();
      send_item(OP_LINE, CODE_DLE, 1'b0, rdy);
      if ($urandom_range(0, 3) == 0) send_item(OP_LINE, CODE_DLE, 1'b0, rdy);
      n = $urandom_range(0, 9);
      send_item(OP_LINE, (n < 4) ? CODE_EOT : (n < 8) ? CODE_ENQ : any_byte(),
                $urandom_range(0, 9) == 0, rdy);
      if ($urandom_range(0, 4) == 0) send_item(OP_POP, any_byte(), any_bit(), any_bit());
      n = $urandom_range(0, 9);
      send_item(OP_LINE, (n < 3) ? FN_STATUS : (n < 6) ? FN_WAKE : any_byte(),
                $urandom_range(0, 11) == 0, (n < 8) ? rdy : any_bit());
   endtask

   task automatic test_directed();
      send_item(OP_POP, 8'h00, 1'b0, 1'b0);
      send_item(OP_LINE, 8'h00, 1'b0, 1'b1);
      send_item(OP_LINE, 8'hFF, 1'b1, 1'b0);
      send_item(OP_LINE, 8'hFF, 1'b0, 1'b1);
      send_item(OP_LINE, CODE_DLE, 1'b0, 1'b1);
      send_item(OP_LINE, CODE_EOT, 1'b0, 1'b1);
      send_item(OP_LINE, FN_STATUS, 1'b0, 1'b1);
      send_item(OP_LINE, CODE_DLE, 1'b0, 1'b0);
      send_item(OP_LINE, CODE_DLE, 1'b0, 1'b0);
      send_item(OP_LINE, CODE_ENQ, 1'b0, 1'b0);
      send_item(OP_LINE, FN_WAKE, 1'b0, 1'b0);
      send_item(OP_LINE, CODE_DLE, 1'b0, 1'b1);
      send_item(OP_LINE, CODE_ENQ, 1'b0, 1'b1);
      send_item(OP_LINE, FN_WAKE, 1'b0, 1'b1);
      send_item(OP_LINE, CODE_DLE, 1'b0, 1'b0);
      send_item(OP_LINE, CODE_EOT, 1'b0, 1'b0);
      send_item(OP_LINE, FN_STATUS, 1'b1, 1'b0);
      send_item(OP_LINE, FN_STATUS, 1'b0, 1'b0);
      send_item(OP_LOCAL, CODE_DLE, 1'b0, 1'b0);
      send_item(OP_LOCAL, CODE_EOT, 1'b0, 1'b0);
      send_item(OP_LOCAL, FN_STATUS, 1'b1, 1'b0);
      send_item(OP_POP, 8'hFF, 1'b1, 1'b1);
      send_item(OP_POP, 8'h00, 1'b0, 1'b0);
      send_item(OP_CLEAR, 8'hFF, 1'b1, 1'b1);
      send_item(OP_POP, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_full_ring();
      set_levels(8'hFF, 8'h00);
      for (int i = 0; i < 280; i++)
         send_item((i % 3 == 0) ? OP_LOCAL : OP_LINE, any_byte(),
                   $urandom_range(0, 31) == 0, any_bit());
      for (int i = 0; i < 262; i++) send_item(OP_POP, any_byte(), any_bit(), any_bit());
   endtask

   task automatic test_backpressure();
      set_levels(8'h00, 8'hFF);
      hold_off_cycles = 300;
      for (int i = 0; i < 60; i++)
         send_item((i % 4 == 3) ? OP_POP : OP_LINE, any_byte(), 1'b0, any_bit());
      drain();
   endtask

   task automatic random_traffic(input int count);
      int   goal;
      int   wave_left;
      int   r;
      logic filling;
      goal = items_sent + count;
      wave_left = 0;
      filling = 1'b0;
      while (items_sent < goal) begin
         if (wave_left == 0) begin
            filling = !filling;
            wave_left = $urandom_range(20, 140);
         end
         wave_left--;
         r = $urandom_range(0, 99);
         if (r < (filling ? 12 : 60)) send_item(OP_POP, any_byte(), any_bit(), any_bit());
         else if (r < (filling ? 13 : 61))
            send_item(OP_CLEAR, any_byte(), any_bit(), any_bit());
         else if (r < (filling ? 33 : 72))
            send_item(OP_LOCAL, any_byte(), any_bit(), any_bit());
         else if (r < (filling ? 55 : 84)) send_realtime_command();
         else send_item(OP_LINE, any_byte(), $urandom_range(0, 7) == 0, any_bit());
      end
   endtask

   task automatic test_level_sweep();
      set_levels(8'd200, 8'd230);
      write_csr(8'd2, 8'hAA);
      write_csr(8'hFF, 8'h55);
      random_traffic(220);
      set_levels(8'd40, 8'd90);
      random_traffic(220);
      set_levels(any_byte(), any_byte());
      random_traffic(220);
      set_levels(8'd0, 8'd0);
      random_traffic(220);
   endtask

   task automatic test_steady_stream();
      set_levels(8'd100, 8'd100);
      gaps_on = 1'b0;
      random_traffic(220);
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rx_result_type want;
      rx_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_pop_valid, rsp_pop_byte, rsp_rts_stop, rsp_status_request,
                rsp_wake_request, rsp_overflow, rsp_fill_count};
         if (due_results.size() == 0) begin
            report_mismatch("response transfer with nothing outstanding");
         end else begin
            want = due_results.pop_front();
            if (got.pop_valid !== want.pop_valid)
               report_mismatch($sformatf("pop_valid exp %0d got %0d",
                                         want.pop_valid, got.pop_valid));
            if (got.pop_byte !== want.pop_byte)
               report_mismatch($sformatf("pop_byte exp %02h got %02h",
                                         want.pop_byte, got.pop_byte));
            if (got.rts_stop !== want.rts_stop)
               report_mismatch($sformatf("rts_stop exp %0d got %0d",
                                         want.rts_stop, got.rts_stop));
            if (got.status_request !== want.status_request)
               report_mismatch($sformatf("status_request exp %0d got %0d",
                                         want.status_request, got.status_request));
            if (got.wake_request !== want.wake_request)
               report_mismatch($sformatf("wake_request exp %0d got %0d",
                                         want.wake_request, got.wake_request));
            if (got.overflow !== want.overflow)
               report_mismatch($sformatf("overflow exp %0d got %0d",
                                         want.overflow, got.overflow));
            if (got.fill_count !== want.fill_count)
               report_mismatch($sformatf("fill_count exp %0d got %0d",
                                         want.fill_count, got.fill_count));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_LINE;
      req_rx_byte = '0;
      req_line_error = 1'b0;
      req_printer_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      model_wr = '0;
      model_rd = '0;
      model_phase = PH_IDLE;
      model_rts = 1'b0;
      model_stop = STOP_LEVEL_RESET;
      model_resume = RESUME_LEVEL_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_ring();
      test_backpressure();
      test_level_sweep();
      test_steady_stream();
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
